FILE: src/sddt_pkg.sv
// ----------------------------------------------------------------------------
// sddt_pkg
// Shared types, widths and calendar constants of the serial day to date and
// time unit.
// ----------------------------------------------------------------------------
package sddt_pkg;

   localparam int DAY_W   = 22;
   localparam int FRAC_W  = 32;
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int MDAY_W  = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;

   localparam int REM_W   = 23;   // day remainder, counted from 1600-01-01
   localparam int SECS_W  = 17;   // 0 .. 86400
   localparam int CNT_W   = 5;    // iteration counter within one phase
   localparam int SHIFT_W = 3;    // bit weight of a restoring-division step

   localparam int SECS_PER_DAY  = 86400;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;

   localparam int QUIRK_DAY     = 60;
   localparam int BASE_YEAR     = 1600;
   // days from 1600-01-01 to 1900-01-01 less one or two (the day-one base
   // and the phantom 1900-02-29)
   localparam int OFFSET_LOW    = 109572;
   localparam int OFFSET_HIGH   = 109571;

   localparam int DAYS_400      = 146097;
   localparam int DAYS_CENT_L   = 36525;
   localparam int DAYS_CENT     = 36524;
   localparam int DAYS_QUAD_L   = 1461;
   localparam int DAYS_QUAD     = 1460;
   localparam int DAYS_YEAR_L   = 366;
   localparam int DAYS_YEAR     = 365;

   localparam int D400_LAST     = 4;    // weights 16,8,4,2,1 cycles of 400 years
   localparam int CENT_MAX      = 3;
   localparam int QUAD_MAX      = 24;
   localparam int YEAR_MAX      = 3;
   localparam int MON_MAX       = 11;
   localparam int HOUR_LAST     = 4;
   localparam int MIN_LAST      = 5;
   localparam int FEB_INDEX     = 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TIME,
      ST_D400,
      ST_CENT,
      ST_QUAD,
      ST_YEAR,
      ST_MON,
      ST_HOUR,
      ST_MIN,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      DP_IDLE,
      DP_LOAD,
      DP_TIME,
      DP_D400,
      DP_CENT,
      DP_QUAD,
      DP_YEAR,
      DP_MON,
      DP_HOUR,
      DP_MIN
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      push;
   } dp_cmd_type;

   typedef struct packed {
      logic date_valid;
      logic done;
   } dp_status_type;

   typedef struct packed {
      logic                 date_valid;
      logic [YEAR_W-1:0]    year;
      logic [MONTH_W-1:0]   month;
      logic [MDAY_W-1:0]    day_of_month;
      logic [HOUR_W-1:0]    hour;
      logic [MIN_W-1:0]     minute;
      logic [SEC_W-1:0]     second;
   } result_type;

   function automatic logic [MDAY_W-1:0] month_length(input logic [MONTH_W-1:0] idx);
      logic [MDAY_W-1:0] len;
      case (idx)
         4'd1:                    len = 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

FILE: src/sddt_ifs.sv
// ----------------------------------------------------------------------------
// sddt request and response channels
// Valid/ready channels carrying one serial day beat in and one date/time
// beat out.
// ----------------------------------------------------------------------------
interface sddt_req_if import sddt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DAY_W-1:0]  day_count;
   logic [FRAC_W-1:0] day_fraction;

   modport source (output valid, day_count, day_fraction, input ready);
   modport sink   (input valid, day_count, day_fraction, output ready);
endinterface

interface sddt_rsp_if import sddt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               date_valid;
   logic [YEAR_W-1:0]  year;
   logic [MONTH_W-1:0] month;
   logic [MDAY_W-1:0]  day_of_month;
   logic [HOUR_W-1:0]  hour;
   logic [MIN_W-1:0]   minute;
   logic [SEC_W-1:0]   second;

   modport source (output valid, date_valid, year, month, day_of_month, hour, minute,
                   second, input ready);
   modport sink   (input valid, date_valid, year, month, day_of_month, hour, minute,
                   second, output ready);
endinterface

FILE: src/sddt_ctrl.sv
// ----------------------------------------------------------------------------
// sddt_ctrl
// Sequencer: steps the datapath through its reduction phases, one per state.
// ----------------------------------------------------------------------------
module sddt_ctrl import sddt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          out_free,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_TIME;
         ST_TIME: state_in = status.date_valid ? ST_D400 : ST_HOUR;
         ST_D400: if (status.done) state_in = ST_CENT;
         ST_CENT: if (status.done) state_in = ST_QUAD;
         ST_QUAD: if (status.done) state_in = ST_YEAR;
         ST_YEAR: if (status.done) state_in = ST_MON;
         ST_MON:  if (status.done) state_in = ST_HOUR;
         ST_HOUR: if (status.done) state_in = ST_MIN;
         ST_MIN:  if (status.done) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.op    = DP_IDLE;
      cmd.push  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = DP_LOAD;
         end
         ST_TIME: cmd.op = DP_TIME;
         ST_D400: cmd.op = DP_D400;
         ST_CENT: cmd.op = DP_CENT;
         ST_QUAD: cmd.op = DP_QUAD;
         ST_YEAR: cmd.op = DP_YEAR;
         ST_MON:  cmd.op = DP_MON;
         ST_HOUR: cmd.op = DP_HOUR;
         ST_MIN:  cmd.op = DP_MIN;
         ST_DONE: cmd.push = out_free;
         default: cmd.op = DP_IDLE;
      endcase
   end

endmodule

FILE: src/sddt_dpath.sv
// ----------------------------------------------------------------------------
// sddt_dpath
// Datapath: day remainder reduction by 400-year, century, 4-year, year and
// month steps, then the time of day by restoring division.
// ----------------------------------------------------------------------------
module sddt_dpath import sddt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   input  logic [DAY_W-1:0]  day_count,
   input  logic [FRAC_W-1:0] day_fraction,
   output dp_status_type     status,
   output result_type        result
);

   localparam int PROD_W = FRAC_W + SECS_W;

   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               first_cent_ff, first_cent_in;
   logic               leap_ff, leap_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic               valid_ff, valid_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [SECS_W-1:0]  secs_ff, secs_in;
   logic [HOUR_W-1:0]  hour_ff, hour_in;
   logic [MIN_W-1:0]   minute_ff, minute_in;

   logic               done;
   logic [SHIFT_W-1:0] k_d400, k_hour, k_min;
   logic [REM_W-1:0]   len_d400, len_cent, len_quad, len_year, len_mon, rem_load;
   logic               short_quad;
   logic [SECS_W-1:0]  len_hour, len_min;
   logic [PROD_W-1:0]  prod;

   assign k_d400   = SHIFT_W'(D400_LAST) - cnt_ff[SHIFT_W-1:0];
   assign k_hour   = SHIFT_W'(HOUR_LAST) - cnt_ff[SHIFT_W-1:0];
   assign k_min    = SHIFT_W'(MIN_LAST) - cnt_ff[SHIFT_W-1:0];
   assign len_d400 = REM_W'(DAYS_400) << k_d400;
   assign len_cent = first_cent_ff ? REM_W'(DAYS_CENT_L) : REM_W'(DAYS_CENT);
   // first 4-year group of a century other than the first has no leap day
   assign short_quad = (cnt_ff == '0) && !first_cent_ff;
   assign len_quad = short_quad ? REM_W'(DAYS_QUAD) : REM_W'(DAYS_QUAD_L);
   assign len_year = leap_ff ? REM_W'(DAYS_YEAR_L) : REM_W'(DAYS_YEAR);
   assign len_mon  = REM_W'(month_length(cnt_ff[MONTH_W-1:0]))
                   + REM_W'((cnt_ff == CNT_W'(FEB_INDEX)) && leap_ff);
   assign len_hour = SECS_W'(SECS_PER_HOUR) << k_hour;
   assign len_min  = SECS_W'(SECS_PER_MIN) << k_min;
   assign rem_load = REM_W'(day_count)
                   + ((day_count > DAY_W'(QUIRK_DAY)) ? REM_W'(OFFSET_HIGH)
                                                      : REM_W'(OFFSET_LOW));
   assign prod     = PROD_W'(frac_ff) * PROD_W'(SECS_PER_DAY)
                   + PROD_W'(64'h8000_0000);

   always_comb begin
      rem_in        = rem_ff;
      year_in       = year_ff;
      first_cent_in = first_cent_ff;
      leap_in       = leap_ff;
      month_in      = month_ff;
      valid_in      = valid_ff;
      frac_in       = frac_ff;
      secs_in       = secs_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      done          = 1'b0;
      case (cmd.op)
         DP_LOAD: begin
            rem_in        = rem_load;
            year_in       = YEAR_W'(BASE_YEAR);
            first_cent_in = 1'b1;
            month_in      = '0;
            valid_in      = (day_count != '0);
            frac_in       = day_fraction;
            done          = 1'b1;
         end
         DP_TIME: begin
            secs_in   = prod[PROD_W-1:FRAC_W];
            hour_in   = '0;
            minute_in = '0;
            done      = 1'b1;
         end
         DP_D400: begin
            if (rem_ff >= len_d400) begin
               rem_in  = rem_ff - len_d400;
               year_in = year_ff + (YEAR_W'(400) << k_d400);
            end
            done = (cnt_ff == CNT_W'(D400_LAST));
         end
         DP_CENT: begin
            if (rem_ff >= len_cent && cnt_ff < CNT_W'(CENT_MAX)) begin
               rem_in        = rem_ff - len_cent;
               year_in       = year_ff + YEAR_W'(100);
               first_cent_in = 1'b0;
            end else begin
               done = 1'b1;
            end
         end
         DP_QUAD: begin
            if (rem_ff >= len_quad && cnt_ff < CNT_W'(QUAD_MAX)) begin
               rem_in  = rem_ff - len_quad;
               year_in = year_ff + YEAR_W'(4);
            end else begin
               leap_in = !short_quad;
               done    = 1'b1;
            end
         end
         DP_YEAR: begin
            if (rem_ff >= len_year && cnt_ff < CNT_W'(YEAR_MAX)) begin
               rem_in  = rem_ff - len_year;
               year_in = year_ff + YEAR_W'(1);
               leap_in = 1'b0;
            end else begin
               done = 1'b1;
            end
         end
         DP_MON: begin
            if (rem_ff >= len_mon && cnt_ff < CNT_W'(MON_MAX)) begin
               rem_in = rem_ff - len_mon;
            end else begin
               month_in = cnt_ff[MONTH_W-1:0] + MONTH_W'(1);
               done     = 1'b1;
            end
         end
         DP_HOUR: begin
            if (secs_ff >= len_hour) begin
               secs_in = secs_ff - len_hour;
               hour_in = hour_ff | (HOUR_W'(1) << k_hour);
            end
            done = (cnt_ff == CNT_W'(HOUR_LAST));
         end
         DP_MIN: begin
            if (secs_ff >= len_min) begin
               secs_in   = secs_ff - len_min;
               minute_in = minute_ff | (MIN_W'(1) << k_min);
            end
            done = (cnt_ff == CNT_W'(MIN_LAST));
         end
         default: done = 1'b0;
      endcase
   end

   assign cnt_in = (done || cmd.op == DP_IDLE) ? '0 : cnt_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      year_ff       <= year_in;
      first_cent_ff <= first_cent_in;
      leap_ff       <= leap_in;
      month_ff      <= month_in;
      valid_ff      <= valid_in;
      frac_ff       <= frac_in;
      secs_ff       <= secs_in;
      hour_ff       <= hour_in;
      minute_ff     <= minute_in;
   end

   assign status.date_valid = valid_ff;
   assign status.done       = done;

   assign result.date_valid   = valid_ff;
   assign result.year         = valid_ff ? year_ff : '0;
   assign result.month        = valid_ff ? month_ff : '0;
   assign result.day_of_month = valid_ff ? rem_ff[MDAY_W-1:0] + MDAY_W'(1) : '0;
   assign result.hour         = hour_ff;
   assign result.minute       = minute_ff;
   assign result.second       = secs_ff[SEC_W-1:0];

endmodule

FILE: src/serial_day_to_date_time_unit.sv
// ----------------------------------------------------------------------------
// serial_day_to_date_time_unit
// Converts a spreadsheet serial day (whole days plus a 32-bit day fraction)
// to a Gregorian date and a time of day.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one beat: day_count and day_fraction. rsp_bus returns one
//   beat per request: date_valid, year, month, day_of_month, hour, minute and
//   second. Day count 0 gives a cleared date with date_valid low.
//   The sequencer converts one beat at a time: a multiply step, a 5-step
//   400-year reduction, up to 4 century, 25 four-year, 4 year and 12 month
//   steps, then 5 hour and 6 minute restoring-division steps and the
//   hand-over. Day count 0 skips the date steps. A new request is taken
//   only once the previous result has been handed to the output register.
//   A finished beat sits in the output register; a new request is accepted
//   while it waits. If the receiver stalls, the next result is held in the
//   sequencer until the output register frees.
//   Synchronous reset empties the output register, returns the sequencer
//   to idle and clears the datapath step counter; nothing else needs clearing.
// ----------------------------------------------------------------------------
module serial_day_to_date_time_unit import sddt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   sddt_req_if.sink   req_bus,
   sddt_rsp_if.source rsp_bus
);

   dp_cmd_type    cmd;
   dp_status_type status;
   result_type    result;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_data_ff;
   logic          out_free;

   // free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   sddt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .out_free  (out_free),
      .status    (status),
      .cmd       (cmd)
   );

   sddt_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .day_count    (req_bus.day_count),
      .day_fraction (req_bus.day_fraction),
      .status       (status),
      .result       (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: loaded on hand-over only
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.date_valid   = rsp_data_ff.date_valid;
   assign rsp_bus.year         = rsp_data_ff.year;
   assign rsp_bus.month        = rsp_data_ff.month;
   assign rsp_bus.day_of_month = rsp_data_ff.day_of_month;
   assign rsp_bus.hour         = rsp_data_ff.hour;
   assign rsp_bus.minute       = rsp_data_ff.minute;
   assign rsp_bus.second       = rsp_data_ff.second;

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for serial_day_to_date_time_unit. Directed serials
// (epoch, the phantom leap day, leap years, calendar ends, full-day
// rounding, rounding ties) are followed by random beats over four phases of
// sender idling and receiver stalling. Every request beat is predicted in
// the bench and each response beat is compared field by field.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sddt_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned DRAIN_CYCLES = 100;    // above the worst-case latency
   localparam int unsigned HOLD_CYCLES = 300;     // long receiver hold-off
   localparam int unsigned HOLD_AFTER = 700;      // responses seen before the hold-off
   localparam int unsigned PHASE_BEATS = 500;
   localparam logic [DAY_W-1:0] LAST_SERIAL = 22'd2958465;   // 9999-12-31

   // -------------------------------------------------------------------------
   // Scoreboard: predicts each request beat and checks responses in order.
   // -------------------------------------------------------------------------
   class date_time_scoreboard;
      result_type  pending_dates[$];
      int unsigned checked_count = 0;
      int unsigned mismatch_count = 0;
      int unsigned days_in_month[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

      function automatic bit leap_year(int unsigned yr);
         return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
      endfunction

      function automatic int unsigned year_length(int unsigned yr);
         return leap_year(yr) ? 366 : 365;
      endfunction

      function automatic result_type predict_date_time(logic [DAY_W-1:0] day,
                                                       logic [FRAC_W-1:0] frac);
         result_type  r;
         int unsigned days_left;
         int unsigned yr;
         int unsigned mon;
         int unsigned mon_len;
         int unsigned secs;
         logic [63:0] scaled;
         r = '0;
         if (day != '0) begin
            days_left = 32'(day);
            // serials past the phantom 1900-02-29 are one day ahead
            if (days_left > QUIRK_DAY) days_left--;
            days_left--;
            yr = 1900;
            while (days_left >= year_length(yr)) begin
               // whole 400-year cycles in one go, once aligned
               if ((yr % 400 == 0) && (days_left >= DAYS_400)) begin
                  days_left -= DAYS_400;
                  yr += 400;
               end else begin
                  days_left -= year_length(yr);
                  yr++;
               end
            end
            mon = 0;
            mon_len = days_in_month[0];
            while (days_left >= mon_len) begin
               days_left -= mon_len;
               mon++;
               mon_len = days_in_month[mon] + ((mon == 1 && leap_year(yr)) ? 1 : 0);
            end
            r.date_valid   = 1'b1;
            r.year         = YEAR_W'(yr);
            r.month        = MONTH_W'(mon + 1);
            r.day_of_month = MDAY_W'(days_left + 1);
         end
         // fraction times 86400, rounded half up; may reach a full day
         scaled = 64'(frac) * 64'(SECS_PER_DAY) + 64'h0000_0000_8000_0000;
         secs = scaled[63:32];
         r.hour   = HOUR_W'(secs / SECS_PER_HOUR);
         r.minute = MIN_W'((secs % SECS_PER_HOUR) / SECS_PER_MIN);
         r.second = SEC_W'(secs % SECS_PER_MIN);
         return r;
      endfunction

      function void note_request(logic [DAY_W-1:0] day, logic [FRAC_W-1:0] frac);
         pending_dates.insert(pending_dates.size(), predict_date_time(day, frac));
      endfunction

      function automatic bit compare_field(string name, int unsigned want,
                                           int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void check_response(result_type got);
         result_type want;
         bit         bad;
         checked_count++;
         if (pending_dates.size() == 0) begin
            $display("%0t: response beat with no request outstanding, got %p", $time, got);
            mismatch_count++;
            return;
         end
         want = pending_dates.pop_front();
         bad = compare_field("date_valid", 32'(want.date_valid), 32'(got.date_valid));
         bad |= compare_field("year", 32'(want.year), 32'(got.year));
         bad |= compare_field("month", 32'(want.month), 32'(got.month));
         bad |= compare_field("day_of_month", 32'(want.day_of_month),
                              32'(got.day_of_month));
         bad |= compare_field("hour", 32'(want.hour), 32'(got.hour));
         bad |= compare_field("minute", 32'(want.minute), 32'(got.minute));
         bad |= compare_field("second", 32'(want.second), 32'(got.second));
         if (bad) mismatch_count++;
      endfunction

      function int unsigned pending();
         return pending_dates.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   sddt_req_if req_bus ();
   sddt_rsp_if rsp_bus ();

   date_time_scoreboard date_sb = new();

   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned cycle_count = 0;

   serial_day_to_date_time_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5ns clock = 1'b1;
      #5ns clock = 1'b0;
   end

   // run limit, far beyond the slowest correct run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response monitor: values read at the edge are the pre-edge ones
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         date_sb.check_response('{date_valid:   rsp_bus.date_valid,
                                  year:         rsp_bus.year,
                                  month:        rsp_bus.month,
                                  day_of_month: rsp_bus.day_of_month,
                                  hour:         rsp_bus.hour,
                                  minute:       rsp_bus.minute,
                                  second:       rsp_bus.second});
      end
   end

   // receiver: random stalls per phase, plus one long hold-off so that the
   // output register and the sequencer fill and the request side backs up
   initial begin
      int unsigned hold_left;
      bit          hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && date_sb.checked_count >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // offer one request beat, after an optional idle gap; returns at the
   // accepting edge with valid still high so that beats can run back to back
   task automatic send_beat(input logic [DAY_W-1:0] day, input logic [FRAC_W-1:0] frac);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.day_count    <= day;
      req_bus.day_fraction <= frac;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      date_sb.note_request(day, frac);
   endtask

   // sender pause until every outstanding beat has come back
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (date_sb.pending() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                            input int unsigned beats);
      logic [DAY_W-1:0]  day;
      logic [FRAC_W-1:0] frac;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int unsigned n = 0; n < beats; n++) begin
         if (n == beats / 2) wait_for_drain();
         case ($urandom_range(9))
            0:       day = DAY_W'($urandom_range(70));          // around the phantom day
            1, 2:    day = DAY_W'($urandom_range(73000, 1));    // 1900 .. 2099
            3, 4, 5, 6: day = DAY_W'($urandom_range(LAST_SERIAL, 1));
            7:       day = DAY_W'($urandom_range(22'h3F_FFFF, LAST_SERIAL - 64));
            default: day = DAY_W'($urandom());                  // whole field
         endcase
         case ($urandom_range(7))
            0:       frac = $urandom_range(32'hFFFF_FFFF, 32'hFFFF_0000);  // near a full day
            // odd multiples of 2^24 sit exactly on a half second
            1:       frac = ($urandom_range(255) << 24) + $urandom_range(4) - 2;
            2:       frac = $urandom_range(255);
            default: frac = $urandom();
         endcase
         send_beat(day, frac);
      end
      wait_for_drain();
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.day_count = '0;
      req_bus.day_fraction = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: epoch, phantom leap day, year ends, leap years, calendar
      // ends, the whole day field, rounding ties and full-day rounding
      send_beat(22'd0, 32'h0000_0000);
      send_beat(22'd0, 32'hFFFF_FFFF);
      send_beat(22'd1, 32'h0000_0000);
      send_beat(22'd59, 32'h8000_0000);
      send_beat(22'd60, 32'd16777216);        // tie: 337.5 s rounds up
      send_beat(22'd61, 32'd16777215);
      send_beat(22'd62, 32'd4294942441);      // first fraction giving hour 24
      send_beat(22'd366, 32'd4294942440);     // last fraction below a full day
      send_beat(22'd367, 32'h5555_5555);
      send_beat(22'd36585, 32'hAAAA_AAAA);    // 2000-02-29
      send_beat(22'd36586, 32'h0000_0001);
      send_beat(22'd36891, 32'h7FFF_FFFF);    // 2000-12-31
      send_beat(22'd73110, 32'h4000_0000);    // 2100, not a leap year
      send_beat(LAST_SERIAL, 32'hC000_0000);
      send_beat(LAST_SERIAL + 22'd1, 32'hFFFF_FFFE);
      send_beat(22'h20_0000, 32'h0000_FFFF);
      send_beat(22'h1F_FFFF, 32'hFFFF_0000);
      send_beat(22'h3F_FFFF, 32'hFFFF_FFFF);
      send_beat(22'h15_5555, 32'h0F0F_0F0F);
      send_beat(22'h2A_AAAA, 32'hF0F0_F0F0);
      wait_for_drain();

      run_phase(0, 0, PHASE_BEATS);
      run_phase(76, 0, PHASE_BEATS);
      run_phase(0, 76, PHASE_BEATS);
      run_phase(33, 33, PHASE_BEATS);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (date_sb.mismatch_count == 0 && date_sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: serial_day_to_date_time_unit.f
src/sddt_pkg.sv
src/sddt_ifs.sv
src/sddt_ctrl.sv
src/sddt_dpath.sv
src/serial_day_to_date_time_unit.sv
verif/testbench.sv
